>>> sv/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

   // Page geometry and field widths.
   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int COUNT_W    = 14;
   localparam int ADDR_W     = 25;
   localparam int FREE_ADDR_W = 32;
   localparam int WORD_BITS  = 32;
   localparam int BIT_W      = $clog2(WORD_BITS);

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = COUNT_W;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PAGES    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_PAGES = 2'd1;

   localparam logic [COUNT_W-1:0] TOTAL_PAGES_RESET    = 14'd8192;
   localparam logic [COUNT_W-1:0] RESERVED_PAGES_RESET = 14'd512;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_INIT  = 2'd2,
      OP_NOP   = 2'd3
   } bpa_opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FREE_CHK,
      ST_INIT,
      ST_RESULT
   } bpa_state_type;

   // Word with the lowest n bits set.
   function automatic logic [WORD_BITS-1:0] low_mask(input logic [BIT_W-1:0] n);
      return (WORD_BITS'(1) << n) - WORD_BITS'(1);
   endfunction

endpackage

>>> sv/bpa_if.sv
// Request and response channel interfaces of the bitmap page allocator.
`timescale 1ns / 1ps

interface bpa_req_if;
   import bpa_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [1:0]             opcode;
   logic [FREE_ADDR_W-1:0] free_addr;

   modport source (output valid, opcode, free_addr, input ready);
   modport sink   (input valid, opcode, free_addr, output ready);
endinterface

interface bpa_rsp_if;
   import bpa_pkg::*;
   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  page_addr;
   logic               granted;
   logic [COUNT_W-1:0] free_count;
   logic [COUNT_W-1:0] used_count;

   modport source (output valid, page_addr, granted, free_count, used_count, input ready);
   modport sink   (input valid, page_addr, granted, free_count, used_count, output ready);
endinterface

>>> sv/bitmap_page_allocator.sv
// Bitmap page frame allocator with a first-fit search over a word-wide memory.
`timescale 1ns / 1ps

// The allocator keeps one used bit per physical page in a synchronous memory
// of 32-bit words and a running count of free pages. A request transaction
// carries an opcode: allocate returns the byte address of the lowest free
// page and marks it used, free clears the bit of the page that holds
// free_addr (out-of-range frees and frees of a free page change nothing),
// init clears the map, latches the page-total register (clipped to
// MAX_PAGES, never above 2**COUNT_W - 1) as the active total and marks the
// lowest reserved_pages pages used, and opcode three only reports the
// counts. Every request yields exactly one response transaction with the
// free and used counts after the operation. The configuration registers act
// only at the next init; until the first init no page is managed and every
// allocate is refused. The single memory read port delivers one bitmap word
// per cycle. An allocate reads words upward from word zero until one holds
// a free page or the last managed word is read (it reads none when the free
// count is already zero), a free whose page lies below the active total
// reads that page's word and writes it back if the page is used, any other
// free and a no-op go straight to the response, and an init writes its fill
// pattern to each of the ceil(active total / 32) words in turn. A new request
// is accepted in the cycle after the response register is loaded, even
// while that response still waits on a stalled sink.
module bitmap_page_allocator #(
   parameter int MAX_PAGES = 8192
) (
   input  logic                               clock,
   input  logic                               reset,
   bpa_req_if.sink                            req,
   bpa_rsp_if.source                          rsp,
   input  logic                               csr_we,
   input  logic [bpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bpa_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bpa_pkg::*;

   // Only pages below 2**COUNT_W can ever be managed, so the memory holds
   // at most that many bits even for a larger MAX_PAGES.
   localparam int MAP_WORDS  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int CNT_WORDS  = (2 ** COUNT_W) / WORD_BITS;
   localparam int SCAN_WORDS = (MAP_WORDS < CNT_WORDS) ? MAP_WORDS : CNT_WORDS;
   localparam int AW         = (SCAN_WORDS > 1) ? $clog2(SCAN_WORDS) : 1;
   localparam int CW         = $clog2(SCAN_WORDS + 1);
   localparam int LIMIT_INT  = (MAX_PAGES < 2 ** COUNT_W) ? MAX_PAGES : 2 ** COUNT_W - 1;
   localparam logic [COUNT_W-1:0] PAGE_LIMIT = COUNT_W'(LIMIT_INT);

   // Bitmap memory: one write port, one registered read port.
   logic [WORD_BITS-1:0] bitmap_mem [SCAN_WORDS];
   logic                 mem_we;
   logic                 mem_re;
   logic [AW-1:0]        mem_waddr;
   logic [AW-1:0]        mem_raddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [WORD_BITS-1:0] mem_rdata_ff;

   // Control and status registers.
   bpa_state_type        state_ff, state_in;
   logic [COUNT_W-1:0]   cfg_total_ff, cfg_total_in;
   logic [COUNT_W-1:0]   cfg_reserved_ff, cfg_reserved_in;
   logic [COUNT_W-1:0]   active_ff, active_in;
   logic [COUNT_W-1:0]   free_ff, free_in;
   logic [COUNT_W-1:0]   reserved_ff, reserved_in;
   logic [CW-1:0]        rd_word_ff, rd_word_in;
   logic [BIT_W-1:0]     bit_pos_ff, bit_pos_in;
   logic [ADDR_W-1:0]    res_addr_ff, res_addr_in;
   logic                 res_granted_ff, res_granted_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic                 rsp_granted_ff, rsp_granted_in;
   logic [COUNT_W-1:0]   rsp_free_ff, rsp_free_in;
   logic [COUNT_W-1:0]   rsp_used_ff, rsp_used_in;

   // Derived values.
   logic                   req_ready;
   logic [CW-1:0]          nwords;
   logic [CW-1:0]          next_word;
   logic [COUNT_W-1:0]     word_idx;
   logic [COUNT_W-1:0]     found_page;
   logic [WORD_BITS-1:0]   scan_mask;
   logic [WORD_BITS-1:0]   scan_avail;
   logic                   scan_hit;
   logic [BIT_W-1:0]       scan_pos;
   logic [WORD_BITS-1:0]   fill_word;
   logic [FREE_ADDR_W-1:0] free_idx;
   logic                   free_in_range;
   logic [COUNT_W-1:0]     init_total;
   logic [COUNT_W-1:0]     init_resv;

   assign nwords    = CW'((15'(active_ff) + 15'd31) >> BIT_W);
   assign next_word = rd_word_ff + CW'(1);
   assign word_idx  = COUNT_W'(rd_word_ff);

   // Bits of the current word that lie below the active total.
   always_comb begin
      if (word_idx < (active_ff >> BIT_W)) begin
         scan_mask = '1;
      end else if (word_idx == (active_ff >> BIT_W)) begin
         scan_mask = low_mask(active_ff[BIT_W-1:0]);
      end else begin
         scan_mask = '0;
      end
   end

   // Find the lowest free page in the word just read.
   assign scan_avail = ~mem_rdata_ff & scan_mask;
   assign scan_hit   = |scan_avail;

   always_comb begin
      scan_pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (scan_avail[i]) begin
            scan_pos = BIT_W'(i);
         end
      end
   end

   assign found_page = {word_idx[COUNT_W-BIT_W-1:0], scan_pos};

   // Init fill pattern: reserved pages of the current word are marked used.
   always_comb begin
      if (word_idx < (reserved_ff >> BIT_W)) begin
         fill_word = '1;
      end else if (word_idx == (reserved_ff >> BIT_W)) begin
         fill_word = low_mask(reserved_ff[BIT_W-1:0]);
      end else begin
         fill_word = '0;
      end
   end

   assign free_idx      = req.free_addr >> PAGE_SHIFT;
   assign free_in_range = free_idx < FREE_ADDR_W'(active_ff);

   assign init_total = (cfg_total_ff > PAGE_LIMIT) ? PAGE_LIMIT : cfg_total_ff;
   assign init_resv  = (cfg_reserved_ff > init_total) ? init_total : cfg_reserved_ff;

   // Next state and datapath control.
   always_comb begin
      state_in        = state_ff;
      cfg_total_in    = cfg_total_ff;
      cfg_reserved_in = cfg_reserved_ff;
      active_in       = active_ff;
      free_in         = free_ff;
      reserved_in     = reserved_ff;
      rd_word_in      = rd_word_ff;
      bit_pos_in      = bit_pos_ff;
      res_addr_in     = res_addr_ff;
      res_granted_in  = res_granted_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_addr_in     = rsp_addr_ff;
      rsp_granted_in  = rsp_granted_ff;
      rsp_free_in     = rsp_free_ff;
      rsp_used_in     = rsp_used_ff;
      req_ready       = 1'b0;
      mem_we          = 1'b0;
      mem_re          = 1'b0;
      mem_waddr       = rd_word_ff[AW-1:0];
      mem_raddr       = rd_word_ff[AW-1:0];
      mem_wdata       = mem_rdata_ff;

      // Configuration writes; indexes beyond the register list are ignored.
      if (csr_we) begin
         case (csr_index)
            CSR_TOTAL_PAGES:    cfg_total_in    = csr_wdata;
            CSR_RESERVED_PAGES: cfg_reserved_in = csr_wdata;
            default: ;
         endcase
      end

      // The sink takes the pending response transaction.
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req.valid) begin
               res_addr_in    = '0;
               res_granted_in = 1'b0;
               case (req.opcode)
                  OP_ALLOC: begin
                     // Nothing to find when no page is free.
                     if (free_ff == '0) begin
                        state_in = ST_RESULT;
                     end else begin
                        mem_re     = 1'b1;
                        mem_raddr  = '0;
                        rd_word_in = '0;
                        state_in   = ST_SCAN;
                     end
                  end
                  OP_FREE: begin
                     if (free_in_range) begin
                        mem_re     = 1'b1;
                        mem_raddr  = AW'(free_idx >> BIT_W);
                        rd_word_in = CW'(free_idx >> BIT_W);
                        bit_pos_in = free_idx[BIT_W-1:0];
                        state_in   = ST_FREE_CHK;
                     end else begin
                        state_in = ST_RESULT;
                     end
                  end
                  OP_INIT: begin
                     active_in   = init_total;
                     free_in     = init_total - init_resv;
                     reserved_in = init_resv;
                     rd_word_in  = '0;
                     state_in    = (init_total == '0) ? ST_RESULT : ST_INIT;
                  end
                  default: begin
                     state_in = ST_RESULT;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // One word per cycle; the read of the next word is issued while
            // the current one is examined.
            if (scan_hit) begin
               mem_we         = 1'b1;
               mem_wdata      = mem_rdata_ff | (WORD_BITS'(1) << scan_pos);
               free_in        = free_ff - COUNT_W'(1);
               res_addr_in    = ADDR_W'(found_page) << PAGE_SHIFT;
               res_granted_in = 1'b1;
               state_in       = ST_RESULT;
            end else if (next_word == nwords) begin
               state_in = ST_RESULT;
            end else begin
               mem_re     = 1'b1;
               mem_raddr  = next_word[AW-1:0];
               rd_word_in = next_word;
            end
         end

         ST_FREE_CHK: begin
            // A page that is already free is left alone.
            if (mem_rdata_ff[bit_pos_ff]) begin
               mem_we    = 1'b1;
               mem_wdata = mem_rdata_ff & ~(WORD_BITS'(1) << bit_pos_ff);
               free_in   = free_ff + COUNT_W'(1);
            end
            state_in = ST_RESULT;
         end

         ST_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = fill_word;
            if (next_word == nwords) begin
               state_in = ST_RESULT;
            end else begin
               rd_word_in = next_word;
            end
         end

         ST_RESULT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_addr_in    = res_addr_ff;
               rsp_granted_in = res_granted_ff;
               rsp_free_in    = free_ff;
               rsp_used_in    = active_ff - free_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Bitmap memory.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= bitmap_mem[mem_raddr];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cfg_total_ff    <= TOTAL_PAGES_RESET;
         cfg_reserved_ff <= RESERVED_PAGES_RESET;
         active_ff       <= '0;
         free_ff         <= '0;
         reserved_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cfg_total_ff    <= cfg_total_in;
         cfg_reserved_ff <= cfg_reserved_in;
         active_ff       <= active_in;
         free_ff         <= free_in;
         reserved_ff     <= reserved_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_word_ff     <= rd_word_in;
      bit_pos_ff     <= bit_pos_in;
      res_addr_ff    <= res_addr_in;
      res_granted_ff <= res_granted_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_free_ff    <= rsp_free_in;
      rsp_used_ff    <= rsp_used_in;
   end

   assign req.ready      = req_ready;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.page_addr  = rsp_addr_ff;
   assign rsp.granted    = rsp_granted_ff;
   assign rsp.free_count = rsp_free_ff;
   assign rsp.used_count = rsp_used_ff;

`ifndef NO_ASSERTIONS
   a_free_le_total: assert property (@(posedge clock) disable iff (reset)
      free_ff <= active_ff)
      else $error("free page count exceeds the active total");

   a_grant_takes_page: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scan_hit) |=> free_ff == $past(free_ff) - COUNT_W'(1))
      else $error("granted allocation did not decrement the free count");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> rd_word_ff < nwords)
      else $error("scan ran past the last managed word");

   a_refused_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.granted) |-> rsp.page_addr == '0)
      else $error("refused response carries a nonzero page address");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_SCAN || state_ff == ST_FREE_CHK || state_ff == ST_INIT))
      else $error("bitmap written outside a modify state");
`endif

endmodule

>>> tb/bitmap_page_allocator_tb.sv
// Self-checking testbench of the bitmap page allocator with its own page-map predictor.
`timescale 1ns / 1ps

// The bench drives request transactions through the req channel and checks
// every response transaction against a predictor that keeps its own copy of
// the page map, the free count, the active total and the two limit
// registers. A short directed table covers the refusals before the first
// init, grants and frees around the reserved region, double frees,
// out-of-range frees, a full map, an empty map, clipping of both registers
// and the rule that register writes only act at the next init. Random phases
// follow, each with its own page limits. Up to half of their frees return pages
// that were granted earlier, so allocate and free sequences run deep into
// the map. Both sides idle at random, one phase runs without any idling, one
// phase holds the response side off for a long stretch, and every
// reconfiguration waits until all responses are back.
module bitmap_page_allocator_tb;
   import bpa_pkg::*;

   localparam int PAGE_CAPACITY  = 8192;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 80;
   localparam int IDLE_PERCENT   = 22;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 20;
   localparam int CYCLE_LIMIT    = 3_000_000;

   // Register indexes that the block does not decode; writes to them are ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_B = 2'd3;

   // One response transaction, field by field.
   typedef struct packed {
      logic [ADDR_W-1:0]  page_addr;
      logic               granted;
      logic [COUNT_W-1:0] free_count;
      logic [COUNT_W-1:0] used_count;
   } page_report_type;

   typedef enum logic {
      ROW_REQ,
      ROW_CFG
   } row_kind_type;

   // One line of the directed table: either a request or a pair of limit
   // writes. A request row carries a typed-in response when one is obvious.
   typedef struct {
      row_kind_type       kind;
      bpa_opcode_type     op;
      logic [31:0]        addr;
      logic [COUNT_W-1:0] total;
      logic [COUNT_W-1:0] reserved;
      bit                 typed;
      page_report_type    want;
   } directed_row_type;

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bpa_req_if req_if ();
   bpa_rsp_if rsp_if ();

   bitmap_page_allocator #(
      .MAX_PAGES (PAGE_CAPACITY)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state: the page map, the counts and the limit registers.
   bit                 page_used [PAGE_CAPACITY];
   int unsigned        pred_free;
   int unsigned        active_pages;
   logic [COUNT_W-1:0] limit_total;
   logic [COUNT_W-1:0] limit_reserved;

   // Responses still owed by the block, oldest first.
   page_report_type pending_reports[$];
   // Byte addresses of pages granted since the last init, used to build
   // frees that actually return a page.
   logic [ADDR_W-1:0] live_grants[$];

   // Traffic shaping shared between the request and response sides.
   bit calm;
   bit long_hold_req;

   int unsigned error_count;
   int unsigned requests_sent;
   int unsigned reports_checked;
   int unsigned grants_seen;
   int unsigned refusals_seen;
   int unsigned cycle_count;

   directed_row_type directed_rows[$];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic page_report_type report(input int unsigned addr,
                                              input int unsigned granted,
                                              input int unsigned free_cnt,
                                              input int unsigned used_cnt);
      page_report_type r;
      r.page_addr  = ADDR_W'(addr);
      r.granted    = granted[0];
      r.free_count = COUNT_W'(free_cnt);
      r.used_count = COUNT_W'(used_cnt);
      return r;
   endfunction

   function automatic directed_row_type req_row(input bpa_opcode_type op,
                                                input logic [31:0] addr);
      directed_row_type row;
      row.kind     = ROW_REQ;
      row.op       = op;
      row.addr     = addr;
      row.total    = '0;
      row.reserved = '0;
      row.typed    = 1'b0;
      row.want     = '0;
      return row;
   endfunction

   function automatic directed_row_type typed_row(input bpa_opcode_type op,
                                                  input logic [31:0] addr,
                                                  input page_report_type want);
      directed_row_type row;
      row       = req_row(op, addr);
      row.typed = 1'b1;
      row.want  = want;
      return row;
   endfunction

   function automatic directed_row_type cfg_row(input logic [COUNT_W-1:0] total,
                                                input logic [COUNT_W-1:0] reserved);
      directed_row_type row;
      row          = req_row(OP_NOP, '0);
      row.kind     = ROW_CFG;
      row.total    = total;
      row.reserved = reserved;
      return row;
   endfunction

   // Applies one accepted request to the predictor state and returns the
   // response that the block owes for it. Allocation is first fit below the
   // active total; init latches the limits, clipping both of them.
   function automatic page_report_type predict_page_op(input bpa_opcode_type op,
                                                       input logic [31:0] addr);
      page_report_type rep;
      int unsigned     idx;
      int unsigned     t;
      int unsigned     r;
      rep = '0;
      case (op)
         OP_ALLOC: begin
            for (int unsigned i = 0; i < active_pages; i++) begin
               if (!page_used[i]) begin
                  page_used[i]  = 1'b1;
                  pred_free     = pred_free - 1;
                  rep.page_addr = ADDR_W'(i * PAGE_BYTES);
                  rep.granted   = 1'b1;
                  break;
               end
            end
         end
         OP_FREE: begin
            idx = addr >> PAGE_SHIFT;
            if (idx < active_pages && page_used[idx]) begin
               page_used[idx] = 1'b0;
               pred_free      = pred_free + 1;
            end
         end
         OP_INIT: begin
            t = (limit_total > PAGE_CAPACITY) ? PAGE_CAPACITY : limit_total;
            r = (limit_reserved > t) ? t : limit_reserved;
            for (int unsigned i = 0; i < PAGE_CAPACITY; i++) begin
               page_used[i] = (i < r);
            end
            active_pages = t;
            pred_free    = t - r;
         end
         default: begin
         end
      endcase
      rep.free_count = COUNT_W'(pred_free);
      rep.used_count = COUNT_W'(active_pages - pred_free);
      return rep;
   endfunction

   // Offers one request transaction, waits for it to be taken and records
   // the response it must produce. The valid line is only ever assigned once
   // per time step: it stays high into the next request unless a gap falls.
   task automatic issue_request(input bpa_opcode_type op, input logic [31:0] addr,
                                input bit typed, input page_report_type want);
      page_report_type rep;
      if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.opcode    <= op;
      req_if.free_addr <= addr;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      rep = predict_page_op(op, addr);
      requests_sent++;
      if (op == OP_INIT) begin
         live_grants.delete();
      end
      if (rep.granted) begin
         live_grants.push_back(rep.page_addr);
      end
      pending_reports.push_back(typed ? want : rep);
   endtask

   // Stops offering requests and waits until every owed response is back,
   // then lets the block settle so that it is idle for a register write.
   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes both limit registers, optionally followed by a write to an
   // index that the block does not decode.
   task automatic program_limits(input logic [COUNT_W-1:0] total,
                                 input logic [COUNT_W-1:0] reserved, input bit stray);
      csr_we    <= 1'b1;
      csr_index <= CSR_TOTAL_PAGES;
      csr_wdata <= total;
      @(posedge clock);
      csr_index <= CSR_RESERVED_PAGES;
      csr_wdata <= reserved;
      @(posedge clock);
      if (stray) begin
         csr_index <= $urandom_range(1) ? CSR_UNMAPPED_A : CSR_UNMAPPED_B;
         csr_wdata <= CSR_DATA_W'($urandom);
         @(posedge clock);
      end
      csr_we         <= 1'b0;
      limit_total    = total;
      limit_reserved = reserved;
   endtask

   // Compares one response transaction with the oldest owed response.
   task automatic check_report();
      page_report_type exp;
      if (pending_reports.size() == 0) begin
         $display("%0t: response with no request outstanding: addr %h granted %b free %0d used %0d",
                  $time, rsp_if.page_addr, rsp_if.granted, rsp_if.free_count,
                  rsp_if.used_count);
         error_count++;
      end else begin
         exp = pending_reports.pop_front();
         reports_checked++;
         if (rsp_if.granted === 1'b1) grants_seen++;
         if (rsp_if.page_addr !== exp.page_addr) begin
            $display("%0t: page_addr mismatch: expected %h, got %h",
                     $time, exp.page_addr, rsp_if.page_addr);
            error_count++;
         end
         if (rsp_if.granted !== exp.granted) begin
            $display("%0t: granted mismatch: expected %b, got %b",
                     $time, exp.granted, rsp_if.granted);
            error_count++;
         end
         if (rsp_if.free_count !== exp.free_count) begin
            $display("%0t: free_count mismatch: expected %0d, got %0d",
                     $time, exp.free_count, rsp_if.free_count);
            error_count++;
         end
         if (rsp_if.used_count !== exp.used_count) begin
            $display("%0t: used_count mismatch: expected %0d, got %0d",
                     $time, exp.used_count, rsp_if.used_count);
            error_count++;
         end
      end
   endtask

   // Response side: samples the channel at each rising edge, then decides
   // the ready level for the next cycle. A long hold-off, once asked for, is
   // counted down here so the request side can keep pushing meanwhile.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            check_report();
         end
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Watchdog: a run that has not finished by now is hung.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout with %0d responses outstanding", $time, pending_reports.size());
      $display("bitmap_page_allocator verification failed");
      $finish;
   end

   // Stimulus: reset, the directed table, then the random phases.
   initial begin
      directed_row_type   row;
      logic [COUNT_W-1:0] total;
      logic [COUNT_W-1:0] reserved;
      int unsigned        clipped;
      int unsigned        pick;
      int unsigned        slot;
      bpa_opcode_type     op;
      logic [31:0]        addr;

      // Predictor state after reset: no page managed until the first init.
      for (int i = 0; i < PAGE_CAPACITY; i++) page_used[i] = 1'b0;
      pred_free       = 0;
      active_pages    = 0;
      limit_total     = TOTAL_PAGES_RESET;
      limit_reserved  = RESERVED_PAGES_RESET;
      calm            = 1'b0;
      long_hold_req   = 1'b0;
      error_count     = 0;
      requests_sent   = 0;
      reports_checked = 0;
      grants_seen     = 0;
      refusals_seen   = 0;

      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.opcode    <= OP_NOP;
      req_if.free_addr <= '0;
      csr_we           <= 1'b0;
      csr_index        <= CSR_TOTAL_PAGES;
      csr_wdata        <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Before any init every allocate is refused and the counts read zero.
      directed_rows.push_back(typed_row(OP_ALLOC, 32'h0000_0000, report(0, 0, 0, 0)));
      directed_rows.push_back(typed_row(OP_FREE,  32'hFFFF_FFFF, report(0, 0, 0, 0)));
      directed_rows.push_back(typed_row(OP_NOP,   32'h0000_0000, report(0, 0, 0, 0)));
      // Init with the reset limits: 8192 pages, the low 512 reserved.
      directed_rows.push_back(typed_row(OP_INIT,  32'h0000_0000, report(0, 0, 7680, 512)));
      directed_rows.push_back(typed_row(OP_ALLOC, 32'h0000_0000,
                                        report(32'h0020_0000, 1, 7679, 513)));
      directed_rows.push_back(typed_row(OP_ALLOC, 32'h0000_0000,
                                        report(32'h0020_1000, 1, 7678, 514)));
      // Free by an address inside the page, then the same page again, then
      // an address far beyond the managed range.
      directed_rows.push_back(typed_row(OP_FREE,  32'h0020_0ABC, report(0, 0, 7679, 513)));
      directed_rows.push_back(typed_row(OP_FREE,  32'h0020_0000, report(0, 0, 7679, 513)));
      directed_rows.push_back(typed_row(OP_FREE,  32'hFFFF_FFFF, report(0, 0, 7679, 513)));
      // Freeing a reserved page makes it the lowest free page.
      directed_rows.push_back(typed_row(OP_FREE,  32'h0000_0FFF, report(0, 0, 7680, 512)));
      directed_rows.push_back(typed_row(OP_ALLOC, 32'h0000_0000, report(0, 1, 7679, 513)));
      directed_rows.push_back(req_row(OP_ALLOC, 32'h0000_0000));
      // Both limits at their widest; they must not act before the next init.
      directed_rows.push_back(cfg_row(14'h3FFF, 14'h3FFF));
      directed_rows.push_back(req_row(OP_ALLOC, 32'h0000_0000));
      directed_rows.push_back(typed_row(OP_INIT,  32'h0000_0000, report(0, 0, 0, 8192)));
      directed_rows.push_back(typed_row(OP_ALLOC, 32'h0000_0000, report(0, 0, 0, 8192)));
      directed_rows.push_back(typed_row(OP_FREE,  32'h01FF_F000, report(0, 0, 1, 8191)));
      directed_rows.push_back(typed_row(OP_ALLOC, 32'h0000_0000,
                                        report(32'h01FF_F000, 1, 0, 8192)));
      directed_rows.push_back(typed_row(OP_FREE,  32'h0200_0000, report(0, 0, 0, 8192)));
      // An empty map: nothing is managed at all.
      directed_rows.push_back(cfg_row(14'd0, 14'd0));
      directed_rows.push_back(typed_row(OP_INIT,  32'h0000_0000, report(0, 0, 0, 0)));
      directed_rows.push_back(typed_row(OP_ALLOC, 32'h0000_0000, report(0, 0, 0, 0)));
      directed_rows.push_back(typed_row(OP_FREE,  32'h0000_0000, report(0, 0, 0, 0)));
      // A single page, granted once and then refused.
      directed_rows.push_back(cfg_row(14'd1, 14'd0));
      directed_rows.push_back(typed_row(OP_INIT,  32'h0000_0000, report(0, 0, 1, 0)));
      directed_rows.push_back(typed_row(OP_ALLOC, 32'h0000_0000, report(0, 1, 0, 1)));
      directed_rows.push_back(typed_row(OP_ALLOC, 32'h0000_0000, report(0, 0, 0, 1)));
      // More reserved pages than managed ones: the reserve is clipped.
      directed_rows.push_back(cfg_row(14'd40, 14'd100));
      directed_rows.push_back(typed_row(OP_INIT,  32'h0000_0000, report(0, 0, 0, 40)));

      foreach (directed_rows[n]) begin
         row = directed_rows[n];
         if (row.kind == ROW_CFG) begin
            wait_for_drain();
            program_limits(row.total, row.reserved, 1'b1);
         end else begin
            issue_request(row.op, row.addr, row.typed, row.want);
            if (row.op == OP_ALLOC && !pending_reports[$].granted) refusals_seen++;
         end
      end

      // Random phases. Each one waits for the block to drain, programs new
      // limits (mostly small maps so scans stay short, a few at or above the
      // capacity) and then runs a mix dominated by allocates and frees.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_drain();
         calm = (phase == 5);
         pick = $urandom_range(99);
         if (pick < 10) total = COUNT_W'(PAGE_CAPACITY);
         else if (pick < 15) total = COUNT_W'($urandom_range(PAGE_CAPACITY + 1, 16383));
         else if (pick < 22) total = COUNT_W'($urandom_range(0, 3));
         else total = COUNT_W'($urandom_range(4, 300));
         clipped = (total > PAGE_CAPACITY) ? PAGE_CAPACITY : total;
         if ($urandom_range(99) < 10) reserved = COUNT_W'($urandom_range(clipped, 16383));
         else reserved = COUNT_W'($urandom_range(0, clipped / 4));
         program_limits(total, reserved, $urandom_range(2) == 0);

         // The response side stalls for a long while here, so the block
         // fills its response register and then refuses new requests.
         if (phase == 2) long_hold_req = 1'b1;

         // Now and then the phase starts without an init, so the new limits
         // stay latent until an init shows up in the mix.
         if ($urandom_range(3) != 0) issue_request(OP_INIT, $urandom, 1'b0, '0);

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(99);
            addr = $urandom;
            if (pick < 45 || pick >= 95) begin
               op = OP_ALLOC;
            end else if (pick < 85) begin
               op = OP_FREE;
               pick = $urandom_range(99);
               if (pick < 50 && live_grants.size() != 0) begin
                  // Return a page granted earlier, by any address inside it.
                  slot = $urandom_range(live_grants.size() - 1);
                  addr = {7'd0, live_grants[slot][ADDR_W-1:PAGE_SHIFT], addr[PAGE_SHIFT-1:0]};
                  live_grants.delete(slot);
               end else if (pick < 85) begin
                  // A page near the managed range, possibly just past it.
                  addr = {20'($urandom_range(0, active_pages + 3)), addr[PAGE_SHIFT-1:0]};
               end
            end else if (pick < 90) begin
               op = OP_INIT;
            end else begin
               op = OP_NOP;
            end
            issue_request(op, addr, 1'b0, '0);
            if (op == OP_ALLOC && !pending_reports[$].granted) refusals_seen++;
         end
      end

      wait_for_drain();
      calm = 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d requests over %0d random limit settings; %0d responses checked.",
               requests_sent, RANDOM_PHASES, reports_checked);
      $display("Pages granted: %0d, allocates refused: %0d, mismatches: %0d.",
               grants_seen, refusals_seen, error_count);
      if (error_count == 0 && pending_reports.size() == 0) begin
         $display("bitmap_page_allocator verification clean");
      end else begin
         $display("bitmap_page_allocator verification failed");
      end
      $finish;
   end

endmodule
